// File: rtl/core/adpcm4_pkg.sv
`default_nettype none
package adpcm4_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned STEP_W   = 15;
    localparam int unsigned SCALE_W  = 10;
    localparam int unsigned PROD_W   = STEP_W + SCALE_W;
    localparam int unsigned DIVW     = SAMPLE_W + 3;

    localparam logic [STEP_W-1:0] STEP_RST = 15'd127;
    localparam logic [STEP_W-1:0] STEP_MIN = 15'd127;
    localparam logic [STEP_W-1:0] STEP_MAX = 15'd24576;

    typedef struct packed {
        logic       done;
        logic       neg;
        logic [2:0] mag;
    } t_div_res;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } t_mul_res;

    function automatic logic [SCALE_W-1:0] scale_of(input logic [2:0] mag);
        logic [SCALE_W-1:0] s;
        unique case (mag)
            3'd4:    s = 10'h133;
            3'd5:    s = 10'h199;
            3'd6:    s = 10'h200;
            3'd7:    s = 10'h266;
            default: s = 10'h0e6;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/adpcm4_ifs.sv
`default_nettype none
interface adpcm4_in_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  sample_first;
    logic signed [15:0]  sample_second;
    logic                end_of_stream;

    modport source (output valid, sample_first, sample_second, end_of_stream, input ready);
    modport sink   (input valid, sample_first, sample_second, end_of_stream, output ready);
endinterface

interface adpcm4_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       last_byte;

    modport source (output valid, code_byte, last_byte, input ready);
    modport sink   (input valid, code_byte, last_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/core/adpcm_4bit_encoder_unit.sv
// One word (two samples) is coded at a time; a new word is taken only in idle,
// after both samples have passed the serial divider (5 steps) and the
// radix-4 multipliers (5 digits).
// A finished byte waits in the output register while the next word is taken.
// Reset (synchronous, active low): predictor 0, step 127, output empty.
`default_nettype none
module adpcm_4bit_encoder_unit
    import adpcm4_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    adpcm4_in_if.sink     i_in,
    adpcm4_out_if.source  o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_UPD,
        S_FIN
    } t_state;

    t_state                     r_state;
    logic                       r_half;
    logic signed [SAMPLE_W-1:0] r_s1;
    logic signed [SAMPLE_W-1:0] r_s2;
    logic                       r_last;
    logic signed [SAMPLE_W-1:0] r_pred;
    logic [STEP_W-1:0]          r_step;
    logic [2:0]                 r_mag;
    logic                       r_neg;
    logic [7:0]                 r_code;
    logic                       r_div_start;
    logic                       r_mul_start;
    logic                       r_out_valid;
    logic [7:0]                 r_out_code;
    logic                       r_out_last;

    t_div_res                   w_div;
    t_mul_res                   w_mul_s;
    t_mul_res                   w_mul_d;
    logic signed [SAMPLE_W-1:0] w_cur;
    logic signed [SAMPLE_W:0]   w_diff;
    logic signed [SAMPLE_W+1:0] w_delta;
    logic signed [SAMPLE_W+1:0] w_psum;
    logic signed [SAMPLE_W-1:0] w_pnew;
    logic [STEP_W+1:0]          w_sraw;
    logic [STEP_W-1:0]          w_snew;

    assign w_cur  = r_half ? r_s2 : r_s1;
    assign w_diff = {w_cur[SAMPLE_W-1], w_cur} - {r_pred[SAMPLE_W-1], r_pred};

    adpcm4_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_diff  (w_diff),
        .i_step  (r_step),
        .o_res   (w_div)
    );

    adpcm4_mul u_mul_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_step),
        .i_b     (scale_of(r_mag)),
        .o_res   (w_mul_s)
    );

    adpcm4_mul u_mul_delta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_step),
        .i_b     ({6'b000000, r_mag, 1'b1}),
        .o_res   (w_mul_d)
    );

    // predictor: add signed delta, clamp to 16 bits
    assign w_delta = {2'b00, w_mul_d.prod[SAMPLE_W+2:3]};
    assign w_psum  = {{2{r_pred[SAMPLE_W-1]}}, r_pred} + (r_neg ? -w_delta : w_delta);

    always_comb begin
        priority if (w_psum < -18'sd32768) begin
            w_pnew = 16'sh8000;
        end else if (w_psum > 18'sd32767) begin
            w_pnew = 16'sh7fff;
        end else begin
            w_pnew = w_psum[SAMPLE_W-1:0];
        end
    end

    // step: product >> 8, clamp
    assign w_sraw = w_mul_s.prod[PROD_W-1:8];

    always_comb begin
        priority if (w_sraw < {2'b00, STEP_MIN}) begin
            w_snew = STEP_MIN;
        end else if (w_sraw > {2'b00, STEP_MAX}) begin
            w_snew = STEP_MAX;
        end else begin
            w_snew = w_sraw[STEP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_half      <= 1'b0;
            r_pred      <= '0;
            r_step      <= STEP_RST;
            r_div_start <= 1'b0;
            r_mul_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_mul_start <= 1'b0;
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_s1        <= i_in.sample_first;
                        r_s2        <= i_in.sample_second;
                        r_last      <= i_in.end_of_stream;
                        r_half      <= 1'b0;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_mag       <= w_div.mag;
                        r_neg       <= w_div.neg;
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (w_mul_s.done) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_pred <= w_pnew;
                    r_step <= w_snew;
                    if (r_half) begin
                        r_code[7:4] <= {r_neg, r_mag};
                        r_state     <= S_FIN;
                    end else begin
                        r_code[3:0] <= {r_neg, r_mag};
                        r_half      <= 1'b1;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_code  <= r_code;
                        r_out_last  <= r_last;
                        if (r_last) begin
                            r_pred <= '0;
                            r_step <= STEP_RST;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.code_byte = r_out_code;
    assign o_out.last_byte = r_out_last;

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step >= STEP_MIN) && (r_step <= STEP_MAX))
        else $error("step out of range");

    a_div_mul_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_div.done && w_mul_s.done))
        else $error("divider and multiplier finished together");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == S_DIV))
        else $error("divider result outside divide phase");

    a_mul_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_s.done == w_mul_d.done)
        else $error("multipliers out of step");

endmodule
`default_nettype wire

// File: rtl/core/adpcm4_div.sv
`default_nettype none
module adpcm4_div
    import adpcm4_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic signed [SAMPLE_W:0] i_diff,
    input  wire logic [STEP_W-1:0]     i_step,
    output t_div_res                   o_res
);

    logic              r_busy;
    logic              r_done;
    logic [2:0]        r_cnt;
    logic [DIVW-1:0]   r_rem;
    logic [DIVW-1:0]   r_dvs;
    logic [3:0]        r_q;
    logic              r_sat;
    logic              r_neg;

    logic [SAMPLE_W:0] w_abs;
    logic              w_ge;

    assign w_abs = i_diff[SAMPLE_W] ? (~i_diff + 1'b1) : i_diff;
    assign w_ge  = (r_rem >= r_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 3'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // saturation test against 16*step, then one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {w_abs[SAMPLE_W-1:0], 3'b000};
            r_dvs <= {i_step, 4'b0000};
            r_cnt <= 3'd4;
            r_q   <= 4'd0;
            r_sat <= 1'b0;
            r_neg <= i_diff[SAMPLE_W];
        end else if (r_busy) begin
            if (r_cnt == 3'd4) begin
                r_sat <= w_ge;
            end else begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dvs;
                end
                r_q <= {r_q[2:0], w_ge};
            end
            r_dvs <= r_dvs >> 1;
            if (r_cnt != 3'd0) begin
                r_cnt <= r_cnt - 3'd1;
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.mag  = r_sat ? 3'd7 : r_q[3:1];
    assign o_res.neg  = r_neg && (r_sat || r_q != 4'd0);

endmodule
`default_nettype wire

// File: rtl/core/adpcm4_mul.sv
`default_nettype none
module adpcm4_mul
    import adpcm4_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [STEP_W-1:0]  i_a,
    input  wire logic [SCALE_W-1:0] i_b,
    output t_mul_res                o_res
);

    logic               r_busy;
    logic               r_done;
    logic [2:0]         r_cnt;
    logic [STEP_W-1:0]  r_a;
    logic [SCALE_W-1:0] r_b;
    logic [PROD_W-1:0]  r_acc;

    logic [1:0]         w_dig;
    logic [STEP_W+1:0]  w_pp;

    // radix-4, most significant digit first
    assign w_dig = r_b[SCALE_W-1 -: 2];
    assign w_pp  = ({2'b00, r_a} & {(STEP_W+2){w_dig[0]}})
                 + ({1'b0, r_a, 1'b0} & {(STEP_W+2){w_dig[1]}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 3'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
            r_cnt <= 3'd4;
        end else if (r_busy) begin
            r_acc <= {r_acc[PROD_W-3:0], 2'b00} + PROD_W'(w_pp);
            r_b   <= {r_b[SCALE_W-3:0], 2'b00};
            if (r_cnt != 3'd0) begin
                r_cnt <= r_cnt - 3'd1;
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.prod = r_acc;

endmodule
`default_nettype wire

// File: test/adpcm_4bit_encoder_unit_checker.sv
`default_nettype none
module adpcm_4bit_encoder_unit_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    adpcm4_in_if      in_ch,
    adpcm4_out_if     out_ch,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int SIG_LO  = -32768;
    localparam int SIG_HI  = 32767;
    localparam int STEP_LO = 127;
    localparam int STEP_HI = 24576;
    localparam int ADAPT_GAIN [8] = '{'h0e6, 'h0e6, 'h0e6, 'h0e6, 'h133, 'h199, 'h200, 'h266};

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
    } t_coded_word;

    t_coded_word bytes_due[$];
    int          pred_sig;
    int          step_now;

    function automatic int clip(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // codes one sample and advances predictor and step
    function automatic logic [3:0] code_sample(input int sample);
        int         quot;
        int         mag;
        int         delta;
        logic [3:0] nib;
        quot = ((sample - pred_sig) * 8) / step_now;
        mag  = ((quot < 0) ? -quot : quot) / 2;
        if (mag > 7) begin
            mag = 7;
        end
        nib   = {quot < 0, 3'(mag)};
        delta = (step_now * (2 * mag + 1)) / 8;
        if (nib[3]) begin
            delta = -delta;
        end
        pred_sig = clip(pred_sig + delta, SIG_LO, SIG_HI);
        step_now = clip((step_now * ADAPT_GAIN[mag]) >>> 8, STEP_LO, STEP_HI);
        return nib;
    endfunction

    always @(posedge i_clk) begin : watch
        t_coded_word want;
        logic [3:0]  nib_lo;
        logic [3:0]  nib_hi;
        if (!i_rst_n) begin
            pred_sig     = 0;
            step_now     = STEP_LO;
            o_fail_count = 0;
            bytes_due.delete();
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                nib_lo = code_sample(int'(in_ch.sample_first));
                nib_hi = code_sample(int'(in_ch.sample_second));
                want.code_byte = {nib_hi, nib_lo};
                want.last_byte = in_ch.end_of_stream;
                bytes_due.push_back(want);
                if (in_ch.end_of_stream) begin
                    pred_sig = 0;
                    step_now = STEP_LO;
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                if (bytes_due.size() == 0) begin
                    $display("%0t: unexpected word, actual code_byte %h last_byte %b",
                             $time, out_ch.code_byte, out_ch.last_byte);
                    o_fail_count++;
                end else begin
                    want = bytes_due.pop_front();
                    if (out_ch.code_byte !== want.code_byte) begin
                        $display("%0t: code_byte expected %h actual %h",
                                 $time, want.code_byte, out_ch.code_byte);
                        o_fail_count++;
                    end
                    if (out_ch.last_byte !== want.last_byte) begin
                        $display("%0t: last_byte expected %b actual %b",
                                 $time, want.last_byte, out_ch.last_byte);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending <= bytes_due.size();
    end

endmodule
`default_nettype wire

// File: test/adpcm_4bit_encoder_unit_tb.sv
`default_nettype none
module adpcm_4bit_encoder_unit_tb;

    localparam int RAND_WORDS  = 1600;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_AT     = 3000;
    localparam int HOLD_LEN    = 400;
    localparam int SINK_CALM0  = 20000;
    localparam int SINK_CALM1  = 26000;
    localparam int SRC_CALM0   = 500;
    localparam int SRC_CALM1   = 800;

    typedef struct {
        logic signed [15:0] s_first;
        logic signed [15:0] s_second;
        logic               eos;
    } t_pcm_pair;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;

    t_pcm_pair pairs[$];

    adpcm4_in_if  in_ch ();
    adpcm4_out_if out_ch ();

    adpcm_4bit_encoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    adpcm_4bit_encoder_unit_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic int sat16(input int v);
        return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
    endfunction

    function automatic int jitter(input int amp);
        return int'($urandom_range(0, 2 * amp)) - amp;
    endfunction

    function automatic int any16();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic void add_pair(input int a, input int b, input logic last);
        t_pcm_pair p;
        p.s_first  = 16'(a);
        p.s_second = 16'(b);
        p.eos      = last;
        pairs.push_back(p);
    endfunction

    // receiver: random back-pressure, one long hold-off, one calm stretch
    initial begin : sink_side
        int cyc;
        cyc = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc >= HOLD_AT && cyc < HOLD_AT + HOLD_LEN) begin
                out_ch.ready <= 1'b0;
            end else if (cyc >= SINK_CALM0 && cyc < SINK_CALM1) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= 25);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : source_side
        int n_rand;
        int len;
        int mode;
        int amp;
        int va;
        int vb;
        int k;
        logic last;

        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.sample_first  = '0;
        in_ch.sample_second = '0;
        in_ch.end_of_stream = 1'b0;

        // directed words
        add_pair(0, 0, 1'b0);             // tiny negative difference, sign stays clear
        add_pair(-1, -1, 1'b0);
        add_pair(1, -1, 1'b0);
        repeat (4) add_pair(32767, 32767, 1'b0);
        repeat (4) add_pair(-32768, -32768, 1'b0);
        repeat (4) add_pair(32767, -32768, 1'b0);   // step to ceiling, predictor clamps
        add_pair(0, 0, 1'b1);
        add_pair(100, 0, 1'b1);           // lone padded pair
        repeat (3) add_pair(0, 0, 1'b0);  // step stays at floor
        add_pair(-32768, 32767, 1'b0);
        add_pair(12345, -12345, 1'b0);
        add_pair(21845, -21846, 1'b1);

        n_rand = 0;
        va     = 0;
        while (n_rand < RAND_WORDS) begin
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 80);
            mode = $urandom_range(0, 3);
            amp  = 1 << $urandom_range(2, 14);
            va   = any16();
            for (k = 0; k < len; k++) begin
                case (mode)
                    0: begin
                        va = any16();
                        vb = any16();
                    end
                    1: begin
                        va = sat16(va + jitter(amp));
                        vb = sat16(va + jitter(amp));
                        va = vb;
                    end
                    2: begin
                        va = jitter(8);
                        vb = jitter(8);
                    end
                    default: begin
                        va = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
                        vb = ($urandom_range(0, 2) == 0) ? any16() : -va - 1;
                    end
                endcase
                last = (k == len - 1);
                if (last && $urandom_range(0, 3) == 0) begin
                    vb = 0;
                end
                add_pair(va, vb, last);
                n_rand++;
            end
        end

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (pairs[i]) begin
            while (!(i >= SRC_CALM0 && i < SRC_CALM1) && $urandom_range(0, 99) < 25) begin
                in_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
            in_ch.valid         <= 1'b1;
            in_ch.sample_first  <= pairs[i].s_first;
            in_ch.sample_second <= pairs[i].s_second;
            in_ch.end_of_stream <= pairs[i].eos;
            do @(posedge i_clk); while (!in_ch.ready);
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
